>>> design/tcgf_pkg.sv
// Package for the timed command gate framer: kind, opcode and register
// codes, frame constants and small helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcgf_pkg;

  // Command kinds as held in state (input kind plus one)
  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_SHOCK   = 3'd1,
    KIND_VIBRATE = 3'd2,
    KIND_BEEP    = 3'd3,
    KIND_LIGHT   = 3'd4
  } kind_t;

  // Event opcodes
  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_STOP = 2'd1,
    OP_POLL = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FRAME_FORMAT = 3'd0,
    REG_DEVICE_ID    = 3'd1,
    REG_SHOCK_DUR    = 3'd2,
    REG_VIBRATE_DUR  = 3'd3,
    REG_SHOCK_LIMIT  = 3'd4,
    REG_VIBRATE_LIM  = 3'd5,
    REG_COOLDOWN     = 3'd6
  } reg_idx_t;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned DUR_MS_W    = 18;  // 255 * 1000 fits in 18 bits
  localparam int unsigned FRAME_W     = 43;
  localparam int unsigned FRAME_BITS_W = 6;

  localparam logic [9:0]              MS_PER_S      = 10'd1000;
  localparam logic [7:0]              CODE_MARK     = 8'h80;
  localparam logic [7:0]              CHECK_INVERT  = 8'hFF;
  localparam logic [FRAME_BITS_W-1:0] FRAME_BITS_L0 = 6'd40;
  localparam logic [FRAME_BITS_W-1:0] FRAME_BITS_L1 = 6'd43;

  // Seconds to milliseconds (constant multiply, narrow)
  function automatic logic [DUR_MS_W-1:0] sec_to_ms(input logic [7:0] s);
    sec_to_ms = DUR_MS_W'(s) * DUR_MS_W'(MS_PER_S);
  endfunction

  // Code byte for the 40-bit layout
  function automatic logic [7:0] code_l0(input kind_t k);
    case (k)
      KIND_SHOCK:   code_l0 = 8'b0000_0001;
      KIND_VIBRATE: code_l0 = 8'b0000_0010;
      KIND_BEEP:    code_l0 = 8'b0000_0100;
      KIND_LIGHT:   code_l0 = 8'b0000_1000;
      default:      code_l0 = 8'b0000_0000;
    endcase
  endfunction

  // Code byte for the 43-bit layout (beep and light swapped)
  function automatic logic [7:0] code_l1(input kind_t k);
    case (k)
      KIND_SHOCK:   code_l1 = 8'b0000_0001;
      KIND_VIBRATE: code_l1 = 8'b0000_0010;
      KIND_BEEP:    code_l1 = 8'b0000_1000;
      KIND_LIGHT:   code_l1 = 8'b0000_0100;
      default:      code_l1 = 8'b0000_0000;
    endcase
  endfunction

  // Bit reversal of a byte
  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    rev8 = r;
  endfunction

endpackage

`default_nettype wire

>>> design/timed_command_gate_framer.sv
// Timed command gate framer top level; depends on tcgf_pkg.
// An accepted input beat passes the input register and then the result
// register. Throughput: one event per cycle while the result channel is
// not stalled; state is updated as the event leaves the input register.
// Reset (synchronous, rst_n low): clears valid flags, command state and all
// configuration registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module timed_command_gate_framer (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // configuration write port
  input  wire logic                                  cfg_we,
  input  wire logic [tcgf_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  wire logic [tcgf_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // event channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            in_opcode,
  input  wire logic [1:0]                            in_kind,
  input  wire logic [7:0]                            in_strength,
  input  wire logic [tcgf_pkg::TIME_W-1:0]           in_now_ms,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_send,
  output logic [tcgf_pkg::FRAME_W-1:0]               out_frame,
  output logic [tcgf_pkg::FRAME_BITS_W-1:0]          out_frame_bits
);

  localparam int unsigned TW = tcgf_pkg::TIME_W;
  localparam int unsigned DW = tcgf_pkg::DUR_MS_W;

  // Configuration registers
  logic        frame_format_r;
  logic [15:0] device_id_r;
  logic [7:0]  shock_dur_r;
  logic [7:0]  vibrate_dur_r;
  logic [7:0]  shock_limit_r;
  logic [7:0]  vibrate_limit_r;
  logic [7:0]  cooldown_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_format_r  <= 1'b0;
      device_id_r     <= '0;
      shock_dur_r     <= '0;
      vibrate_dur_r   <= '0;
      shock_limit_r   <= '0;
      vibrate_limit_r <= '0;
      cooldown_r      <= '0;
    end else if (cfg_we) begin
      case (tcgf_pkg::reg_idx_t'(cfg_idx))
        tcgf_pkg::REG_FRAME_FORMAT: frame_format_r  <= cfg_wdata[0];
        tcgf_pkg::REG_DEVICE_ID:    device_id_r     <= cfg_wdata;
        tcgf_pkg::REG_SHOCK_DUR:    shock_dur_r     <= cfg_wdata[7:0];
        tcgf_pkg::REG_VIBRATE_DUR:  vibrate_dur_r   <= cfg_wdata[7:0];
        tcgf_pkg::REG_SHOCK_LIMIT:  shock_limit_r   <= cfg_wdata[7:0];
        tcgf_pkg::REG_VIBRATE_LIM:  vibrate_limit_r <= cfg_wdata[7:0];
        tcgf_pkg::REG_COOLDOWN:     cooldown_r      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: the input register advances when the result register
  // is empty or its beat is being taken
  logic s1_valid_r;
  logic out_valid_r;
  logic advance;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  // Input register
  logic [1:0]    s1_opcode_r;
  logic [1:0]    s1_kind_r;
  logic [7:0]    s1_strength_r;
  logic [TW-1:0] s1_now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_opcode_r   <= in_opcode;
      s1_kind_r     <= in_kind;
      s1_strength_r <= in_strength;
      s1_now_r      <= in_now_ms;
    end
  end

  // Command state
  logic              active_r, active_nxt;
  tcgf_pkg::kind_t   cur_kind_r, cur_kind_nxt;
  logic [7:0]        cur_strength_r, cur_strength_nxt;
  logic [TW-1:0]     start_time_r, start_time_nxt;
  logic [TW-1:0]     end_time_r, end_time_nxt;

  // Shared arithmetic for one event
  tcgf_pkg::kind_t kind_new;
  logic [7:0]      limit_new;
  logic [DW-1:0]   dur_new_ms;
  logic [DW-1:0]   dur_cur_ms;
  logic [DW-1:0]   window_ms;
  logic [7:0]      cooldown_eff;
  logic [TW-1:0]   used_ms;
  logic [TW-1:0]   since_end;
  logic [TW-1:0]   elapsed;
  logic [TW-1:0]   limit_end;
  logic            time_ok;
  logic            may_send;

  assign kind_new     = tcgf_pkg::kind_t'({1'b0, s1_kind_r} + 3'd1);
  assign limit_new    = (kind_new == tcgf_pkg::KIND_SHOCK) ? shock_limit_r : vibrate_limit_r;
  assign dur_new_ms   = tcgf_pkg::sec_to_ms(
                          (kind_new == tcgf_pkg::KIND_SHOCK) ? shock_dur_r : vibrate_dur_r);
  assign dur_cur_ms   = tcgf_pkg::sec_to_ms(
                          (cur_kind_r == tcgf_pkg::KIND_SHOCK) ? shock_dur_r : vibrate_dur_r);
  assign cooldown_eff = (cooldown_r == 8'd0) ? 8'd1 : cooldown_r;
  assign window_ms    = tcgf_pkg::sec_to_ms(cooldown_eff);
  assign used_ms      = end_time_r - start_time_r;
  assign since_end    = s1_now_r - end_time_r;
  assign elapsed      = s1_now_r - start_time_r;
  assign limit_end    = start_time_r + TW'(dur_cur_ms);

  // Only shock and vibrate runs are time bounded
  assign time_ok  = !(((cur_kind_r == tcgf_pkg::KIND_SHOCK) ||
                       (cur_kind_r == tcgf_pkg::KIND_VIBRATE)) &&
                      (elapsed > TW'(dur_cur_ms)));
  assign may_send = active_r && (cur_kind_r != tcgf_pkg::KIND_NONE) && time_ok;

  // Frame assembly for both layouts
  logic [7:0]                    code0, code1, csum;
  logic [tcgf_pkg::FRAME_W-1:0]  frame_l0, frame_l1;

  assign code0    = tcgf_pkg::code_l0(cur_kind_r) | tcgf_pkg::CODE_MARK;
  assign code1    = tcgf_pkg::code_l1(cur_kind_r);
  assign csum     = cur_strength_r + code1 + device_id_r[7:0] + device_id_r[15:8];
  assign frame_l0 = {3'b000, code0, device_id_r, cur_strength_r,
                     tcgf_pkg::rev8(code0 ^ tcgf_pkg::CHECK_INVERT)};
  assign frame_l1 = {device_id_r, code1, cur_strength_r, csum, 3'b000};

  // Next state and result for the event in the input register
  logic                              send_nxt;
  logic [tcgf_pkg::FRAME_W-1:0]      frame_nxt;
  logic [tcgf_pkg::FRAME_BITS_W-1:0] frame_bits_nxt;

  always_comb begin
    active_nxt       = active_r;
    cur_kind_nxt     = cur_kind_r;
    cur_strength_nxt = cur_strength_r;
    start_time_nxt   = start_time_r;
    end_time_nxt     = end_time_r;
    send_nxt         = 1'b0;
    frame_nxt        = '0;
    frame_bits_nxt   = '0;
    case (tcgf_pkg::op_t'(s1_opcode_r))
      tcgf_pkg::OP_SET: begin
        active_nxt       = 1'b1;
        cur_kind_nxt     = kind_new;
        cur_strength_nxt = (s1_strength_r < limit_new) ? s1_strength_r : limit_new;
        // restart inside the cool-down window resumes the unused budget
        if (since_end < TW'(window_ms)) begin
          if (used_ms < TW'(dur_new_ms)) begin
            start_time_nxt = s1_now_r - used_ms;
          end
        end else begin
          start_time_nxt = s1_now_r;
        end
      end
      tcgf_pkg::OP_STOP: begin
        active_nxt   = 1'b0;
        end_time_nxt = (s1_now_r < limit_end) ? s1_now_r : limit_end;
      end
      tcgf_pkg::OP_POLL: begin
        if (may_send) begin
          send_nxt = 1'b1;
          if (frame_format_r) begin
            frame_nxt      = frame_l1;
            frame_bits_nxt = tcgf_pkg::FRAME_BITS_L1;
          end else begin
            frame_nxt      = frame_l0;
            frame_bits_nxt = tcgf_pkg::FRAME_BITS_L0;
          end
        end
      end
      default: ;
    endcase
  end

  // State update as the event leaves the input register
  logic fire;
  assign fire = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r       <= 1'b0;
      cur_kind_r     <= tcgf_pkg::KIND_NONE;
      cur_strength_r <= '0;
      start_time_r   <= '0;
      end_time_r     <= '0;
    end else if (fire) begin
      active_r       <= active_nxt;
      cur_kind_r     <= cur_kind_nxt;
      cur_strength_r <= cur_strength_nxt;
      start_time_r   <= start_time_nxt;
      end_time_r     <= end_time_nxt;
    end
  end

  // Result register
  logic                              out_send_r;
  logic [tcgf_pkg::FRAME_W-1:0]      out_frame_r;
  logic [tcgf_pkg::FRAME_BITS_W-1:0] out_frame_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_send_r       <= send_nxt;
      out_frame_r      <= frame_nxt;
      out_frame_bits_r <= frame_bits_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_send       = out_send_r;
  assign out_frame      = out_frame_r;
  assign out_frame_bits = out_frame_bits_r;

  // Checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with an empty input register");

  a_send_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_send_r) |->
      (out_frame_bits_r == tcgf_pkg::FRAME_BITS_L0 ||
       out_frame_bits_r == tcgf_pkg::FRAME_BITS_L1))
    else $error("frame sent with a bad bit count");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_send_r) |-> (out_frame_r == '0 && out_frame_bits_r == '0))
    else $error("non-sending result carries frame bits");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(start_time_r) && $stable(end_time_r) && $stable(active_r)))
    else $error("command state changed without an event");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_opcode_r == tcgf_pkg::OP_STOP) |=> !active_r)
    else $error("stop left the command active");

endmodule

`default_nettype wire

>>> bench/timed_command_gate_framer_test.sv
// Self-checking bench for timed_command_gate_framer: directed and random event
// beats in bursts against random back-pressure, scored by an in-bench model.
// Depends on tcgf_pkg and the timed_command_gate_framer RTL.
`timescale 1ns / 1ps

module timed_command_gate_framer_test;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PRINT_CAP    = 100;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic [1:0] IN_SHOCK    = 2'd0;
  localparam logic [1:0] IN_VIBRATE  = 2'd1;
  localparam logic [1:0] IN_BEEP     = 2'd2;
  localparam logic [1:0] IN_LIGHT    = 2'd3;

  localparam logic       FMT_REVERSED = 1'b0;
  localparam logic       FMT_SUM      = 1'b1;
  localparam logic [31:0] MS_PER_SEC  = 32'd1000;
  localparam logic [7:0] MARK_BIT     = 8'h80;
  localparam logic [7:0] INVERT_ALL   = 8'hFF;
  localparam logic [7:0] CODE_SHOCK   = 8'h01;
  localparam logic [7:0] CODE_VIBRATE = 8'h02;
  localparam logic [7:0] CODE_BEEP    = 8'h04;
  localparam logic [7:0] CODE_LIGHT   = 8'h08;
  localparam logic [5:0] LEN_REVERSED = 6'd40;
  localparam logic [5:0] LEN_SUM      = 6'd43;

  localparam int PHASE_MAX    = 0;
  localparam int PHASE_MIN    = 1;
  localparam int PHASE_RANDOM = 2;

  localparam int unsigned STALL_NONE   = 0;
  localparam int unsigned STALL_RANDOM = 1;
  localparam int unsigned STALL_TOGGLE = 2;

  // One queued beat: either a register write or an event
  typedef struct {
    logic                 is_write;
    tcgf_pkg::reg_idx_t   reg_sel;
    logic [15:0]          reg_val;
    logic [1:0]           op;
    logic [1:0]           kind;
    logic [7:0]           strength;
    logic [31:0]          now_ms;
  } stim_t;

  typedef struct {
    logic                              send;
    logic [tcgf_pkg::FRAME_W-1:0]      frame;
    logic [tcgf_pkg::FRAME_BITS_W-1:0] nbits;
  } tx_t;

  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              cfg_we    = 1'b0;
  logic [tcgf_pkg::CFG_IDX_W-1:0]    cfg_idx   = '0;
  logic [tcgf_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;
  logic                              in_valid  = 1'b0;
  logic                              in_stall;
  logic [1:0]                        in_opcode   = '0;
  logic [1:0]                        in_kind     = '0;
  logic [7:0]                        in_strength = '0;
  logic [tcgf_pkg::TIME_W-1:0]       in_now_ms   = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              out_send;
  logic [tcgf_pkg::FRAME_W-1:0]      out_frame;
  logic [tcgf_pkg::FRAME_BITS_W-1:0] out_frame_bits;

  stim_t event_queue[$];
  tx_t   frame_queue[$];
  stim_t cur_beat;

  // Model copy of the registers and the command state (reset values)
  logic            fmt_sel   = 1'b0;
  logic [15:0]     dev_id    = '0;
  logic [7:0]      shock_s   = '0;
  logic [7:0]      vib_s     = '0;
  logic [7:0]      shock_lim = '0;
  logic [7:0]      vib_lim   = '0;
  logic [7:0]      cool_s    = '0;
  logic            cmd_on    = 1'b0;
  tcgf_pkg::kind_t cmd_kind  = tcgf_pkg::KIND_NONE;
  logic [7:0]      cmd_str   = '0;
  logic [31:0]     run_start = '0;
  logic [31:0]     run_end   = '0;

  int unsigned events_total = 0;
  int unsigned events_taken = 0;
  int unsigned results_seen = 0;
  int unsigned error_count  = 0;
  int unsigned holds_done   = 0;
  int unsigned n_set = 0, n_stop = 0, n_poll = 0, n_reserved = 0, n_frames = 0;
  int unsigned n_writes = 0, n_settings = 0;

  timed_command_gate_framer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_kind        (in_kind),
    .in_strength    (in_strength),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_send       (out_send),
    .out_frame      (out_frame),
    .out_frame_bits (out_frame_bits)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Model of the gate and framer
  // ---------------------------------------------------------------------------

  // Run budget of a kind in ms; anything but shock uses the vibrate duration
  function automatic logic [31:0] run_ms(input tcgf_pkg::kind_t k);
    run_ms = 32'((k == tcgf_pkg::KIND_SHOCK) ? shock_s : vib_s) * MS_PER_SEC;
  endfunction

  function automatic void apply_write(input stim_t w);
    case (w.reg_sel)
      tcgf_pkg::REG_FRAME_FORMAT: fmt_sel   = w.reg_val[0];
      tcgf_pkg::REG_DEVICE_ID:    dev_id    = w.reg_val;
      tcgf_pkg::REG_SHOCK_DUR:    shock_s   = w.reg_val[7:0];
      tcgf_pkg::REG_VIBRATE_DUR:  vib_s     = w.reg_val[7:0];
      tcgf_pkg::REG_SHOCK_LIMIT:  shock_lim = w.reg_val[7:0];
      tcgf_pkg::REG_VIBRATE_LIM:  vib_lim   = w.reg_val[7:0];
      tcgf_pkg::REG_COOLDOWN:     cool_s    = w.reg_val[7:0];
      default: ;
    endcase
    n_writes++;
  endfunction

  function automatic tx_t gate_and_frame(input stim_t e);
    tx_t             r;
    tcgf_pkg::kind_t k;
    logic [31:0]     window, used, cap_end, elapsed;
    logic [7:0]      lim, code, inv, chk, csum;
    int              i;
    r.send  = 1'b0;
    r.frame = '0;
    r.nbits = '0;
    k = tcgf_pkg::kind_t'(3'(e.kind) + 3'd1);
    case (e.op)
      tcgf_pkg::OP_SET: begin
        n_set++;
        lim      = (k == tcgf_pkg::KIND_SHOCK) ? shock_lim : vib_lim;
        window   = 32'((cool_s == 8'd0) ? 8'd1 : cool_s) * MS_PER_SEC;
        used     = run_end - run_start;
        cmd_on   = 1'b1;
        cmd_kind = k;
        cmd_str  = (e.strength < lim) ? e.strength : lim;
        // restart inside the cool-down window resumes the unused budget
        if (e.now_ms - run_end < window) begin
          if (used < run_ms(k)) run_start = e.now_ms - used;
        end else begin
          run_start = e.now_ms;
        end
      end
      tcgf_pkg::OP_STOP: begin
        n_stop++;
        cap_end = run_start + run_ms(cmd_kind);
        cmd_on  = 1'b0;
        run_end = (e.now_ms < cap_end) ? e.now_ms : cap_end;
      end
      tcgf_pkg::OP_POLL: begin
        n_poll++;
        elapsed = e.now_ms - run_start;
        // beep and light have no time bound
        if (cmd_on && cmd_kind != tcgf_pkg::KIND_NONE &&
            !((cmd_kind == tcgf_pkg::KIND_SHOCK || cmd_kind == tcgf_pkg::KIND_VIBRATE) &&
              elapsed > run_ms(cmd_kind))) begin
          r.send = 1'b1;
          n_frames++;
          // long layout swaps the beep and light codes
          case (cmd_kind)
            tcgf_pkg::KIND_SHOCK:   code = CODE_SHOCK;
            tcgf_pkg::KIND_VIBRATE: code = CODE_VIBRATE;
            tcgf_pkg::KIND_BEEP:    code = (fmt_sel == FMT_SUM) ? CODE_LIGHT : CODE_BEEP;
            default:                code = (fmt_sel == FMT_SUM) ? CODE_BEEP : CODE_LIGHT;
          endcase
          if (fmt_sel == FMT_REVERSED) begin
            code = code | MARK_BIT;
            inv  = code ^ INVERT_ALL;
            for (i = 0; i < 8; i++) chk[i] = inv[7 - i];
            r.frame = {3'b000, code, dev_id, cmd_str, chk};
            r.nbits = LEN_REVERSED;
          end else begin
            csum    = cmd_str + code + dev_id[7:0] + dev_id[15:8];
            r.frame = {dev_id, code, cmd_str, csum, 3'b000};
            r.nbits = LEN_SUM;
          end
        end
      end
      default: n_reserved++;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  function automatic void push_event(input logic [1:0] op, input logic [1:0] kind,
                                     input logic [7:0] strength, input logic [31:0] now_ms);
    stim_t s;
    s.is_write = 1'b0;
    s.reg_sel  = tcgf_pkg::REG_FRAME_FORMAT;
    s.reg_val  = '0;
    s.op       = op;
    s.kind     = kind;
    s.strength = strength;
    s.now_ms   = now_ms;
    event_queue.push_back(s);
    events_total++;
  endfunction

  function automatic void push_write(input tcgf_pkg::reg_idx_t sel, input logic [15:0] val);
    stim_t s;
    s.is_write = 1'b1;
    s.reg_sel  = sel;
    s.reg_val  = val;
    s.op       = OP_RESERVED;
    s.kind     = '0;
    s.strength = '0;
    s.now_ms   = '0;
    event_queue.push_back(s);
  endfunction

  function automatic void push_settings(input logic fmt, input logic [15:0] id,
                                        input logic [7:0] sd, input logic [7:0] vd,
                                        input logic [7:0] sl, input logic [7:0] vl,
                                        input logic [7:0] cd);
    push_write(tcgf_pkg::REG_FRAME_FORMAT, 16'(fmt));
    push_write(tcgf_pkg::REG_DEVICE_ID, id);
    push_write(tcgf_pkg::REG_SHOCK_DUR, 16'(sd));
    push_write(tcgf_pkg::REG_VIBRATE_DUR, 16'(vd));
    push_write(tcgf_pkg::REG_SHOCK_LIMIT, 16'(sl));
    push_write(tcgf_pkg::REG_VIBRATE_LIM, 16'(vl));
    push_write(tcgf_pkg::REG_COOLDOWN, 16'(cd));
    n_settings++;
  endfunction

  // Mostly well-formed runs (set, polls around the budget edge, stop, restart)
  // with some noise beats at near or far times
  task automatic add_random_phase(input int n_events, input int flavor);
    logic        fmt;
    logic [15:0] id;
    logic [7:0]  sd, vd, sl, vl, cd;
    logic [1:0]  kind, op;
    logic [31:0] t, anchor, dur, pt;
    int          made, npoll, i;
    case (flavor)
      PHASE_MAX: begin
        fmt = FMT_SUM; id = 16'hFFFF;
        sd = 8'hFF; vd = 8'hFF; sl = 8'hFF; vl = 8'hFF; cd = 8'hFF;
      end
      PHASE_MIN: begin
        fmt = FMT_REVERSED; id = 16'h0000;
        sd = 8'h00; vd = 8'h00; sl = 8'h00; vl = 8'h00; cd = 8'h00;
      end
      default: begin
        fmt = 1'($urandom_range(0, 1));
        id  = 16'($urandom());
        sd  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 4)) : 8'($urandom());
        vd  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 4)) : 8'($urandom());
        sl  = 8'($urandom());
        vl  = 8'($urandom());
        cd  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom());
      end
    endcase
    push_settings(fmt, id, sd, vd, sl, vl, cd);

    t    = $urandom();
    made = 0;
    while (made < n_events) begin
      if ($urandom_range(0, 9) < 8) begin
        kind   = 2'($urandom_range(0, 3));
        dur    = 32'((kind == IN_SHOCK) ? sd : vd) * MS_PER_SEC;
        anchor = t;
        push_event(tcgf_pkg::OP_SET, kind, 8'($urandom()), t);
        npoll = $urandom_range(1, 4);
        for (i = 0; i < npoll; i++) begin
          case ($urandom_range(0, 3))
            0:       pt = anchor + dur - 32'd1 + 32'($urandom_range(0, 2));
            1:       pt = anchor + dur + 32'($urandom_range(0, 2000));
            2:       pt = t + 32'($urandom_range(0, 300));
            default: pt = anchor + 32'($urandom_range(0, 3000));
          endcase
          push_event(tcgf_pkg::OP_POLL, 2'($urandom()), 8'($urandom()), pt);
          t = pt;
        end
        made += npoll + 1;
        if ($urandom_range(0, 9) < 7) begin
          t = t + 32'($urandom_range(0, 2000));
          push_event(tcgf_pkg::OP_STOP, 2'($urandom()), 8'($urandom()), t);
          made++;
        end
        // next run either inside the cool-down window or past it
        if ($urandom_range(0, 3) != 0) t = t + 32'($urandom_range(0, 1500));
        else t = t + 32'(cd) * MS_PER_SEC + 32'($urandom_range(0, 3000));
      end else begin
        op = 2'($urandom_range(0, 3));
        pt = ($urandom_range(0, 3) == 0) ? $urandom() : t + 32'($urandom_range(0, 5000));
        push_event(op, 2'($urandom()), 8'($urandom()), pt);
        if (op != OP_RESERVED) made++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of event beats; register writes only once drained
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    stim_t       head;
    logic        nxt_valid, nxt_we, taken;
    int unsigned taken_total;
    nxt_valid   = in_valid;
    nxt_we      = 1'b0;
    taken       = in_valid && !in_stall;
    taken_total = events_taken + (taken ? 1 : 0);
    if (rst_n) begin
      if (taken) begin
        frame_queue.push_back(gate_and_frame(cur_beat));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (event_queue.size() != 0) begin
          head = event_queue[0];
          if (head.is_write) begin
            if (results_seen == taken_total) begin
              void'(event_queue.pop_front());
              apply_write(head);
              nxt_we    = 1'b1;
              cfg_idx   <= head.reg_sel;
              cfg_wdata <= head.reg_val;
            end
          end else begin
            void'(event_queue.pop_front());
            cur_beat    = head;
            nxt_valid   = 1'b1;
            in_opcode   <= head.op;
            in_kind     <= head.kind;
            in_strength <= head.strength;
            in_now_ms   <= head.now_ms;
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 24);
              gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
          end
        end
      end
    end
    in_valid     <= nxt_valid;
    cfg_we       <= nxt_we;
    events_taken <= taken_total;
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: rotating patterns plus two long hold-offs
  // ---------------------------------------------------------------------------
  int unsigned hold_left    = 0;
  int unsigned mode_left    = 0;
  int unsigned stall_mode   = STALL_NONE;
  int unsigned next_hold_at = 150;

  always @(posedge clk) begin
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (hold_left != 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else if (holds_done < 2 && events_taken >= next_hold_at) begin
      hold_left    = HOLD_CYCLES - 1;
      holds_done++;
      next_hold_at = 420;
      nxt_stall    = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_TOGGLE);
        mode_left  = $urandom_range(5, 40);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:   nxt_stall = 1'b0;
        STALL_RANDOM: nxt_stall = ($urandom_range(0, 1) == 1);
        default:      nxt_stall = ~out_stall;
      endcase
    end
    out_stall <= nxt_stall;
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoring
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    if (error_count < PRINT_CAP) $display("[%0t] mismatch at result %0d: %s",
                                          $time, results_seen, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    tx_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected beat send=%0b frame=%h bits=%0d",
                                  out_send, out_frame, out_frame_bits));
      end else begin
        want = frame_queue.pop_front();
        if (out_send !== want.send)
          report_mismatch($sformatf("send %0b, want %0b", out_send, want.send));
        if (out_frame !== want.frame)
          report_mismatch($sformatf("frame %h, want %h", out_frame, want.frame));
        if (out_frame_bits !== want.nbits)
          report_mismatch($sformatf("frame_bits %0d, want %0d", out_frame_bits, want.nbits));
      end
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d results seen",
               cycle_count, results_seen, events_total);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] t0;
    t0 = 32'hFFFF_FE00;  // runs cross the 32-bit time wrap

    // short budgets, full shock limit, zero vibrate limit, zero cool-down
    push_settings(FMT_REVERSED, 16'hFFFF, 8'd1, 8'd2, 8'hFF, 8'h00, 8'h00);
    push_event(tcgf_pkg::OP_POLL, IN_SHOCK, 8'h00, t0);  // nothing active
    push_event(OP_RESERVED, IN_LIGHT, 8'hFF, 32'hFFFF_FFFF);
    push_event(tcgf_pkg::OP_STOP, IN_SHOCK, 8'h00, t0);  // stop with no kind yet
    push_event(tcgf_pkg::OP_SET, IN_SHOCK, 8'hFF, t0);
    push_event(tcgf_pkg::OP_POLL, IN_SHOCK, 8'h00, t0 + 32'd1000);  // last ms of budget
    push_event(tcgf_pkg::OP_POLL, IN_SHOCK, 8'h00, t0 + 32'd1001);  // one past budget
    push_event(tcgf_pkg::OP_STOP, IN_SHOCK, 8'h00, t0 + 32'd1500);  // end clipped to budget
    push_event(tcgf_pkg::OP_SET, IN_VIBRATE, 8'd200, t0 + 32'd1600); // resume inside window
    push_event(tcgf_pkg::OP_POLL, IN_BEEP, 8'h00, t0 + 32'd2600);
    push_event(tcgf_pkg::OP_POLL, IN_BEEP, 8'h00, t0 + 32'd2601);
    push_event(tcgf_pkg::OP_SET, IN_BEEP, 8'd128, t0 + 32'd2700);
    push_event(tcgf_pkg::OP_POLL, IN_SHOCK, 8'h00, t0 + 32'd900000); // beep has no bound
    push_event(tcgf_pkg::OP_SET, IN_LIGHT, 8'd1, 32'h0000_0000);
    push_event(tcgf_pkg::OP_POLL, IN_SHOCK, 8'h00, 32'h0000_0000);
    push_event(tcgf_pkg::OP_STOP, IN_LIGHT, 8'h00, 32'h0000_0010);
    push_event(tcgf_pkg::OP_POLL, IN_SHOCK, 8'h00, 32'h0000_0020);  // stopped

    // long layout, zero device id, zero shock budget, longest vibrate budget and cool-down
    push_settings(FMT_SUM, 16'h0000, 8'd0, 8'hFF, 8'h00, 8'hFF, 8'hFF);
    push_event(tcgf_pkg::OP_SET, IN_SHOCK, 8'hFF, 32'd100);
    push_event(tcgf_pkg::OP_POLL, IN_SHOCK, 8'h00, 32'd100);
    push_event(tcgf_pkg::OP_SET, IN_VIBRATE, 8'hFF, 32'd200);
    push_event(tcgf_pkg::OP_POLL, IN_SHOCK, 8'h00, 32'd255200);
    push_event(tcgf_pkg::OP_SET, IN_BEEP, 8'hFF, 32'd300000);
    push_event(tcgf_pkg::OP_POLL, IN_SHOCK, 8'h00, 32'd300000);
    push_event(tcgf_pkg::OP_SET, IN_LIGHT, 8'h5A, 32'd300001);
    push_event(tcgf_pkg::OP_POLL, IN_SHOCK, 8'h00, 32'd300001);
    push_event(tcgf_pkg::OP_STOP, IN_LIGHT, 8'h00, 32'd300100);
    push_event(tcgf_pkg::OP_SET, IN_SHOCK, 8'h11, 32'd300200);  // budget already spent
    push_event(tcgf_pkg::OP_POLL, IN_SHOCK, 8'h00, 32'd300200);

    add_random_phase(95, PHASE_MAX);
    add_random_phase(95, PHASE_MIN);
    add_random_phase(95, PHASE_RANDOM);
    add_random_phase(95, PHASE_RANDOM);
    add_random_phase(95, PHASE_RANDOM);
    add_random_phase(95, PHASE_RANDOM);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (event_queue.size() != 0 || results_seen != events_total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_queue.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", frame_queue.size()));

    $display("Covered %0d sets, %0d stops, %0d polls (%0d frames) and %0d reserved opcodes,",
             n_set, n_stop, n_poll, n_frames, n_reserved);
    $display("under %0d register settings (%0d writes) with %0d long receiver hold-offs.",
             n_settings, n_writes, holds_done);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
